### design/kdde_pkg.sv
// kdde_pkg: shared widths, state encoding and the controller/datapath command
// and status bundles of the k-mer dedup delta encoder.
// No dependencies.
`default_nettype none
package kdde_pkg;

  localparam int unsigned KMER_W      = 64;
  localparam int unsigned TAXON_W     = 32;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned CHUNK_BITS  = 15;
  localparam int unsigned WORD_W      = CHUNK_BITS + 1;
  localparam int unsigned NUM_CHUNKS  = (KMER_W + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int unsigned IN_DATA_W   = KMER_W + 2 * TAXON_W + SEQ_W;
  localparam int unsigned OUT_DATA_W  = SEQ_W + WORD_W;
  localparam int unsigned OUT_USER_W  = 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;      // request taken this cycle
    logic snap_close;  // capture the group being closed for emission
    logic flush;       // end of stream: capture open group, clear stream state
    logic count;       // find the top non-zero chunk of the captured delta
    logic emit;        // load one delta word into the output register
  } cmd_t;

  typedef struct packed {
    logic close_need;  // incoming request closes the open group
    logic group_open;
    logic out_free;    // output register can take a word this cycle
    logic last_chunk;  // word being emitted is the least significant one
  } status_t;

endpackage
`default_nettype wire

### design/kdde_ctrl.sv
// kdde_ctrl: sequencer for the k-mer dedup delta encoder.
// Depends on kdde_pkg for the state encoding and command/status bundles.
`default_nettype none
module kdde_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  input  wire               in_tlast,
  output logic              in_tready,
  input  kdde_pkg::status_t sts,
  output kdde_pkg::cmd_t    cmd
);

  kdde_pkg::state_t state_r, state_nxt;
  logic             flush_pend_r, flush_pend_nxt;
  logic             acc;

  assign in_tready = (state_r == kdde_pkg::ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    flush_pend_nxt = flush_pend_r;
    cmd            = '0;
    case (state_r)
      kdde_pkg::ST_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          if (sts.close_need) begin
            cmd.snap_close = 1'b1;
            flush_pend_nxt = in_tlast;
            state_nxt      = kdde_pkg::ST_COUNT;
          end else if (in_tlast) begin
            state_nxt = kdde_pkg::ST_FLUSH;
          end
        end
      end
      kdde_pkg::ST_FLUSH: begin
        cmd.flush      = 1'b1;
        flush_pend_nxt = 1'b0;
        state_nxt      = sts.group_open ? kdde_pkg::ST_COUNT : kdde_pkg::ST_IDLE;
      end
      kdde_pkg::ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = kdde_pkg::ST_EMIT;
      end
      kdde_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_chunk) begin
            state_nxt = flush_pend_r ? kdde_pkg::ST_FLUSH : kdde_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = kdde_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kdde_pkg::ST_IDLE;
      flush_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flush_pend_r <= flush_pend_nxt;
    end
  end

endmodule
`default_nettype wire

### design/kdde_datapath.sv
// kdde_datapath: group tracking, delta capture, chunk selection and the
// output register of the k-mer dedup delta encoder. Depends on kdde_pkg.
`default_nettype none
module kdde_datapath (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire  [kdde_pkg::IN_DATA_W-1:0]          in_tdata,
  input  kdde_pkg::cmd_t                          cmd,
  output kdde_pkg::status_t                       sts,
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  output logic [kdde_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [kdde_pkg::OUT_USER_W-1:0]         out_tuser,
  output logic                                    out_tlast
);

  localparam int unsigned KW   = kdde_pkg::KMER_W;
  localparam int unsigned TW   = kdde_pkg::TAXON_W;
  localparam int unsigned SW   = kdde_pkg::SEQ_W;
  localparam int unsigned CB   = kdde_pkg::CHUNK_BITS;
  localparam int unsigned NC   = kdde_pkg::NUM_CHUNKS;
  localparam int unsigned IW   = kdde_pkg::CHUNK_IDX_W;
  localparam int unsigned PADW = NC * CB;

  logic [KW-1:0] in_kmer;
  logic [TW-1:0] in_rank, in_strain;
  logic [SW-1:0] in_seq;

  assign in_kmer   = in_tdata[KW-1:0];
  assign in_rank   = in_tdata[KW+TW-1:KW];
  assign in_strain = in_tdata[KW+2*TW-1:KW+TW];
  assign in_seq    = in_tdata[KW+2*TW+SW-1:KW+2*TW];

  // open group
  logic          group_open_r;
  logic [KW-1:0] group_kmer_r;
  logic [TW-1:0] group_rank_r, group_strain_r;
  logic [SW-1:0] group_seq_r;
  logic          group_mixed_r;
  logic [KW-1:0] prev_kmer_r;

  // group captured for emission
  logic [KW-1:0] delta_r;
  logic [SW-1:0] emit_seq_r;
  logic          emit_mixed_r;
  logic          emit_end_r;
  logic [IW-1:0] chunk_idx_r;

  // output register
  logic          out_valid_r;
  logic [SW-1:0] out_seq_r;
  logic          out_red_r;
  logic [kdde_pkg::WORD_W-1:0] out_word_r;
  logic          out_elast_r;
  logic          out_slast_r;

  logic          is_pad, in_match;
  logic [KW-1:0] group_delta;
  logic [PADW-1:0] delta_pad;
  logic [CB-1:0] chunk_sel;
  logic [IW-1:0] top_idx;
  logic          last_chunk;

  assign is_pad      = &in_kmer;
  assign in_match    = group_open_r && (in_kmer == group_kmer_r) && (in_rank == group_rank_r);
  assign group_delta = group_kmer_r - prev_kmer_r;
  assign delta_pad   = {{(PADW-KW){1'b0}}, delta_r};
  assign chunk_sel   = delta_pad[chunk_idx_r*CB +: CB];
  assign last_chunk  = (chunk_idx_r == '0);

  // highest chunk with any bit set; zero delta still sends one word
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NC; i++) begin
      if (|delta_pad[i*CB +: CB]) begin
        top_idx = IW'(i);
      end
    end
  end

  assign sts.close_need = !is_pad && group_open_r && !in_match;
  assign sts.group_open = group_open_r;
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.last_chunk = last_chunk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_open_r <= 1'b0;
      prev_kmer_r  <= '0;
    end else begin
      if (cmd.accept && !is_pad && !in_match) begin
        group_open_r <= 1'b1;
      end
      if (cmd.snap_close) begin
        prev_kmer_r <= group_kmer_r;
      end
      if (cmd.flush) begin
        group_open_r <= 1'b0;
        prev_kmer_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !is_pad) begin
      if (in_match) begin
        if (in_strain != group_strain_r) begin
          group_mixed_r <= 1'b1;
        end
      end else begin
        group_kmer_r   <= in_kmer;
        group_rank_r   <= in_rank;
        group_strain_r <= in_strain;
        group_seq_r    <= in_seq;
        group_mixed_r  <= 1'b0;
      end
    end
    if (cmd.snap_close || (cmd.flush && group_open_r)) begin
      delta_r      <= group_delta;
      emit_seq_r   <= group_seq_r;
      emit_mixed_r <= group_mixed_r;
      emit_end_r   <= cmd.flush;
    end
    if (cmd.count) begin
      chunk_idx_r <= top_idx;
    end else if (cmd.emit) begin
      chunk_idx_r <= chunk_idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_seq_r   <= emit_seq_r;
      out_red_r   <= emit_mixed_r;
      out_word_r  <= {last_chunk, chunk_sel};
      out_elast_r <= last_chunk;
      out_slast_r <= last_chunk && emit_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_word_r, out_seq_r};
  assign out_tuser  = {out_slast_r, out_red_r};
  assign out_tlast  = out_elast_r;

endmodule
`default_nettype wire

### design/kmer_dedup_delta_encoder.sv
// kmer_dedup_delta_encoder: top level, joins the sequencer and the datapath.
// Depends on kdde_pkg, kdde_ctrl and kdde_datapath.
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_tvalid / in_tready  | tdata: kmer, rank, strain, seq; tlast: eos
//   out_    | out | out_tvalid / out_tready| tdata: seq, delta word; tlast, tuser
//
// A request that neither closes a group nor ends the stream leaves the sequencer
// idle. Closing a group goes through count and then emit, which sends W delta words
// (1..5); end of stream adds a flush step, then count and emit if a group is flushed.
// The output register stalls the emit sequencer only; one word leaves per cycle
// when not stalled. Reset clears the open-group flag, previous k-mer and output valid.
`default_nettype none
module kmer_dedup_delta_encoder (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // kmer[63:0], rank_taxon[95:64], strain_taxon[127:96], seq_id[159:128]
  input  wire  [kdde_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire                                  in_tlast,   // end_of_stream
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // out_seq_id[31:0], delta_word[47:32]
  output logic [kdde_pkg::OUT_DATA_W-1:0]      out_tdata,
  // redundant[0], stream_last[1]
  output logic [kdde_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast   // entry_last
);

  kdde_pkg::cmd_t    cmd;
  kdde_pkg::status_t sts;

  kdde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kdde_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
